[design/mesh_smooth_vertex_normals_macros.svh]
// Assertion macros shared by the RTL of the vertex normal block.
// Both macros sample on clk and are disabled while rst_n is low.
`ifndef MESH_SMOOTH_VERTEX_NORMALS_MACROS_SVH
`define MESH_SMOOTH_VERTEX_NORMALS_MACROS_SVH

`ifndef NO_ASSERTIONS
`define MSVN_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define MSVN_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MSVN_ASSERT(lbl, prop)
`define MSVN_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[design/msvn_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package msvn_pkg;

    localparam int DEF_MAX_VERTS   = 1024;
    localparam int DEF_MAX_CORNERS = 8;
    localparam int DEF_POS_WIDTH   = 16;

    // Width of one component of a vertex normal sum.
    localparam int SUM_W = 24;

    // Request kinds.
    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_CORNER = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // Result kinds.
    localparam logic RES_FACE   = 1'b0;
    localparam logic RES_VERTEX = 1'b1;

    // Unit length in Q1.14.
    localparam logic [14:0] Q_ONE = 15'd16384;

    typedef struct packed {
        logic               zero;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
    } norm_res_t;

endpackage

`default_nettype wire

[design/msvn_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module msvn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[design/msvn_norm.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "mesh_smooth_vertex_normals_macros.svh"

module msvn_norm #(
    parameter int VecWidth = 24
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic signed [VecWidth-1:0] vx,
    input  logic signed [VecWidth-1:0] vy,
    input  logic signed [VecWidth-1:0] vz,
    output logic                       done,
    output msvn_pkg::norm_res_t        res
);

    import msvn_pkg::*;

    localparam int NW = ((VecWidth > 30) ? VecWidth : 30) + 1;

    typedef enum logic [7:0] {
        N_IDLE  = 8'b00000001,
        N_CHECK = 8'b00000010,
        N_SHIFT = 8'b00000100,
        N_SQ    = 8'b00001000,
        N_SQRT  = 8'b00010000,
        N_DLOAD = 8'b00100000,
        N_DIV   = 8'b01000000,
        N_DONE  = 8'b10000000
    } nstate_t;

    nstate_t state_reg, state_next;
    logic [4:0] cnt_reg;
    logic [1:0] comp_reg;

    logic [NW-1:0] m_reg [3];
    logic [2:0]    neg_reg;
    logic [59:0]   prod_reg;
    logic [61:0]   ss_reg;
    logic [32:0]   rem_reg;
    logic [30:0]   root_reg;
    logic [44:0]   num_reg;
    logic [44:0]   dvs_reg;
    logic [14:0]   q_reg;
    norm_res_t     res_reg;

    logic [NW-1:0] mx;
    logic [NW-1:0] m_sel;
    logic [34:0]   remx;
    logic [34:0]   trial;
    logic          sq_ge;
    logic          div_ge;
    logic [14:0]   q_final;
    logic [15:0]   q_signed;

    function automatic logic [NW-1:0] mag(input logic signed [VecWidth-1:0] v);
        logic [VecWidth-1:0] u;
        u = $unsigned(v[VecWidth-1] ? -v : v);
        return NW'(u);
    endfunction

    always_comb
    begin
        mx = m_reg[0];
        if (m_reg[1] > mx)
        begin
            mx = m_reg[1];
        end
        if (m_reg[2] > mx)
        begin
            mx = m_reg[2];
        end
    end

    // The component under work in the squaring and division steps.
    always_comb
    begin
        case (state_reg == N_SQ ? cnt_reg[1:0] : comp_reg)
            2'd0:    m_sel = m_reg[0];
            2'd1:    m_sel = m_reg[1];
            default: m_sel = m_reg[2];
        endcase
    end

    // One digit of the square root per cycle, two radicand bits at a time.
    assign remx  = {rem_reg, ss_reg[61:60]};
    assign trial = {2'b00, root_reg, 2'b01};
    assign sq_ge = remx >= trial;

    assign div_ge   = num_reg >= dvs_reg;
    assign q_final  = {q_reg[13:0], div_ge};
    assign q_signed = neg_reg[comp_reg] ? -16'(q_final) : 16'(q_final);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            N_IDLE:  if (start) state_next = N_CHECK;
            N_CHECK: state_next = (mx == '0) ? N_DONE : N_SHIFT;
            N_SHIFT:
            begin
                if (mx[NW-1:30] == '0 && mx[29])
                begin
                    state_next = N_SQ;
                end
            end
            N_SQ:    if (cnt_reg == 5'd3) state_next = N_SQRT;
            N_SQRT:  if (cnt_reg == 5'd30) state_next = N_DLOAD;
            N_DLOAD: state_next = N_DIV;
            N_DIV:
            begin
                if (cnt_reg == 5'd14)
                begin
                    state_next = (comp_reg == 2'd2) ? N_DONE : N_DLOAD;
                end
            end
            N_DONE:  state_next = N_IDLE;
            default: state_next = N_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
            cnt_reg   <= '0;
            comp_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                N_SHIFT: cnt_reg <= '0;
                N_SQ:    cnt_reg <= (cnt_reg == 5'd3) ? 5'd0 : cnt_reg + 5'd1;
                N_SQRT:  cnt_reg <= (cnt_reg == 5'd30) ? 5'd0 : cnt_reg + 5'd1;
                N_DLOAD: cnt_reg <= '0;
                N_DIV:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd14)
                    begin
                        comp_reg <= comp_reg + 2'd1;
                    end
                end
                N_CHECK: comp_reg <= '0;
                default: cnt_reg <= '0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            N_IDLE:
            begin
                if (start)
                begin
                    m_reg[0] <= mag(vx);
                    m_reg[1] <= mag(vy);
                    m_reg[2] <= mag(vz);
                    neg_reg  <= {vz[VecWidth-1], vy[VecWidth-1], vx[VecWidth-1]};
                end
            end
            N_CHECK:
            begin
                ss_reg <= '0;
                if (mx == '0)
                begin
                    res_reg <= '{zero: 1'b1, nx: '0, ny: '0, nz: '0};
                end
                else
                begin
                    res_reg.zero <= 1'b0;
                end
            end
            N_SHIFT:
            begin
                // Bring the largest magnitude into [2^29, 2^30), one bit a cycle.
                if (mx[NW-1:30] != '0)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        m_reg[i] <= m_reg[i] >> 1;
                    end
                end
                else if (!mx[29])
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        m_reg[i] <= m_reg[i] << 1;
                    end
                end
            end
            N_SQ:
            begin
                if (cnt_reg != 5'd3)
                begin
                    prod_reg <= m_sel[29:0] * m_sel[29:0];
                end
                if (cnt_reg != 5'd0)
                begin
                    ss_reg <= ss_reg + 62'(prod_reg);
                end
                rem_reg  <= '0;
                root_reg <= '0;
            end
            N_SQRT:
            begin
                rem_reg  <= sq_ge ? 33'(remx - trial) : remx[32:0];
                root_reg <= {root_reg[29:0], sq_ge};
                ss_reg   <= ss_reg << 2;
            end
            N_DLOAD:
            begin
                num_reg <= {1'b0, m_sel[29:0], 14'd0} + 45'(root_reg >> 1);
                dvs_reg <= {root_reg, 14'd0};
                q_reg   <= '0;
            end
            N_DIV:
            begin
                if (div_ge)
                begin
                    num_reg <= num_reg - dvs_reg;
                end
                dvs_reg <= dvs_reg >> 1;
                q_reg   <= q_final;
                if (cnt_reg == 5'd14)
                begin
                    case (comp_reg)
                        2'd0:    res_reg.nx <= q_signed;
                        2'd1:    res_reg.ny <= q_signed;
                        default: res_reg.nz <= q_signed;
                    endcase
                end
            end
            N_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    assign done = (state_reg == N_DONE);
    assign res  = res_reg;

    `MSVN_ASSERT(a_len_range, (state_reg == N_DLOAD) |-> (root_reg[30:29] != 2'b00))
    `MSVN_ASSERT(a_sq_fits, (state_reg == N_SQ) |-> (mx[NW-1:30] == '0))
    `MSVN_ASSERT(a_q_bound, (state_reg == N_DIV) |-> (q_reg <= Q_ONE))

endmodule

`default_nettype wire

[design/mesh_smooth_vertex_normals.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "mesh_smooth_vertex_normals_macros.svh"

// Face normals and smoothed vertex normals over a vertex table of MAX_VERTS
// entries. After reset the block sweeps the normal sums to zero, one entry a
// cycle, and holds item_stall high meanwhile. It then takes one request at a
// time: the vertex index is first reduced modulo MAX_VERTS by repeated
// subtraction, then a vertex load is written or a corner is buffered. A
// closing corner of a face with three or more corners goes through position
// fetch, cross product on one shared multiplier, the normalizer (shift steps,
// squaring, square root and division, or a short path for a zero vector),
// then a read and a saturating write-back per buffered corner to update the
// sums over the one read port and one write port of the sum memory; a vertex
// normal read reads the sums and goes through the normalizer.
// The normalizer, which works one bit or one digit per cycle, sets the rate.
// A finished result sits in an output register, so the next request is taken
// while it waits.
module mesh_smooth_vertex_normals #(
    parameter int MAX_VERTS   = msvn_pkg::DEF_MAX_VERTS,
    parameter int MAX_CORNERS = msvn_pkg::DEF_MAX_CORNERS,
    parameter int POS_WIDTH   = msvn_pkg::DEF_POS_WIDTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic [1:0]         kind,
    input  logic [9:0]         vertex_index,
    input  logic signed [15:0] pos_x,
    input  logic signed [15:0] pos_y,
    input  logic signed [15:0] pos_z,
    input  logic               last_corner,
    output logic               result_valid,
    input  logic               result_stall,
    output logic               result_kind,
    output logic [15:0]        result_index,
    output logic signed [15:0] normal_x,
    output logic signed [15:0] normal_y,
    output logic signed [15:0] normal_z,
    output logic               zero_length
);

    import msvn_pkg::*;

    localparam int AW  = $clog2(MAX_VERTS);
    localparam int RW  = (AW > 10) ? AW : 10;
    localparam int CBW = $clog2(MAX_CORNERS);
    localparam int CCW = $clog2(MAX_CORNERS + 1);
    localparam int PW  = POS_WIDTH;
    localparam int DW  = PW + 1;
    localparam int CW  = (2 * PW + 2 > SUM_W) ? 2 * PW + 2 : SUM_W;

    localparam logic [RW:0]     VERTS_W = (RW + 1)'(MAX_VERTS);
    localparam logic [AW-1:0]   LAST_V  = AW'(MAX_VERTS - 1);
    localparam logic [CCW-1:0]  CORN_W  = CCW'(MAX_CORNERS);
    localparam logic signed [SUM_W:0] SUM_MAX = (SUM_W + 1)'(8388607);
    localparam logic signed [SUM_W:0] SUM_MIN = -(SUM_W + 1)'(8388608);

    typedef enum logic [11:0] {
        S_CLEAR  = 12'b000000000001,
        S_IDLE   = 12'b000000000010,
        S_RED    = 12'b000000000100,
        S_LOAD   = 12'b000000001000,
        S_CORNER = 12'b000000010000,
        S_FETCH  = 12'b000000100000,
        S_CROSS  = 12'b000001000000,
        S_SREAD  = 12'b000010000000,
        S_NSTART = 12'b000100000000,
        S_NORM   = 12'b001000000000,
        S_ACC    = 12'b010000000000,
        S_EMIT   = 12'b100000000000
    } state_t;

    state_t state_reg;

    logic [CCW-1:0] ccount_reg;
    logic [CCW-1:0] nc_reg;
    logic [CCW-1:0] acc_reg;
    logic           ph_reg;
    logic [15:0]    face_cnt_reg;
    logic [15:0]    face_num_reg;
    logic [2:0]     step_reg;
    logic [AW-1:0]  clr_reg;
    logic           res_valid_reg;

    logic [1:0]     kind_reg;
    logic [RW-1:0]  red_reg;
    logic [PW-1:0]  px_reg, py_reg, pz_reg;
    logic           last_reg;
    logic [AW-1:0]  corner_reg [MAX_CORNERS];
    logic [3*PW-1:0] p_reg [3];
    logic signed [2*DW-1:0] prod_reg;
    logic signed [CW-1:0]   c_reg [3];

    logic           res_kind_reg;
    logic [15:0]    res_index_reg;
    norm_res_t      res_reg;

    logic           item_accept;
    logic [PW-1:0]  px_in, py_in, pz_in;
    logic [RW:0]    red_ext;
    logic           red_ge;
    logic [AW-1:0]  vi;
    logic           has_room;
    logic [CCW-1:0] cnt_new;
    logic           out_free;

    logic signed [PW-1:0] pc [3][3];
    logic signed [DW-1:0] a [3];
    logic signed [DW-1:0] b [3];
    logic signed [DW-1:0] op1, op2;

    logic [AW-1:0]   fetch_addr;
    logic [AW-1:0]   acc_addr;
    logic            pos_we;
    logic [3*PW-1:0] pos_rdata;
    logic            sum_we;
    logic [AW-1:0]   sum_waddr;
    logic [AW-1:0]   sum_raddr;
    logic [3*SUM_W-1:0] sum_wdata;
    logic [3*SUM_W-1:0] sum_rdata;
    logic signed [SUM_W-1:0] sx, sy, sz;

    logic                 norm_start;
    logic signed [CW-1:0] nvx, nvy, nvz;
    logic                 norm_done;
    norm_res_t            norm_res;

    assign item_stall  = (state_reg != S_IDLE);
    assign item_accept = item_valid && !item_stall;

    if (POS_WIDTH >= 16)
    begin : g_pos_wide
        assign px_in = PW'($unsigned(pos_x));
        assign py_in = PW'($unsigned(pos_y));
        assign pz_in = PW'($unsigned(pos_z));
    end
    else
    begin : g_pos_narrow
        assign px_in = pos_x[PW-1:0];
        assign py_in = pos_y[PW-1:0];
        assign pz_in = pos_z[PW-1:0];
    end

    assign red_ext  = {1'b0, red_reg};
    assign red_ge   = red_ext >= VERTS_W;
    assign vi       = red_reg[AW-1:0];
    assign has_room = ccount_reg < CORN_W;
    assign cnt_new  = ccount_reg + CCW'(has_room);
    assign out_free = !res_valid_reg || !result_stall;

    // Edge vectors of the face: a = p0 - p1 and b = p1 - p2.
    always_comb
    begin
        for (int v = 0; v < 3; v++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                pc[v][j] = p_reg[v][j*PW +: PW];
            end
        end
        for (int j = 0; j < 3; j++)
        begin
            a[j] = DW'(pc[0][j]) - DW'(pc[1][j]);
            b[j] = DW'(pc[1][j]) - DW'(pc[2][j]);
        end
    end

    always_comb
    begin
        case (step_reg)
            3'd0:    begin op1 = a[1]; op2 = b[2]; end
            3'd1:    begin op1 = a[2]; op2 = b[1]; end
            3'd2:    begin op1 = a[2]; op2 = b[0]; end
            3'd3:    begin op1 = a[0]; op2 = b[2]; end
            3'd4:    begin op1 = a[0]; op2 = b[1]; end
            3'd5:    begin op1 = a[1]; op2 = b[0]; end
            default: begin op1 = a[0]; op2 = b[0]; end
        endcase
    end

    function automatic logic [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] s,
                                                 input logic signed [15:0] n);
        logic signed [SUM_W:0] t;
        t = (SUM_W + 1)'(s) + (SUM_W + 1)'(n);
        if (t > SUM_MAX)
        begin
            t = SUM_MAX;
        end
        else if (t < SUM_MIN)
        begin
            t = SUM_MIN;
        end
        return t[SUM_W-1:0];
    endfunction

    assign fetch_addr = (step_reg < 3'd3) ? corner_reg[CBW'(step_reg[1:0])] : '0;
    assign acc_addr   = corner_reg[acc_reg[CBW-1:0]];

    assign sx = sum_rdata[SUM_W-1:0];
    assign sy = sum_rdata[2*SUM_W-1:SUM_W];
    assign sz = sum_rdata[3*SUM_W-1:2*SUM_W];

    always_comb
    begin
        pos_we    = 1'b0;
        sum_we    = 1'b0;
        sum_waddr = vi;
        sum_wdata = '0;
        sum_raddr = (state_reg == S_SREAD) ? vi : acc_addr;
        unique case (state_reg)
            S_CLEAR:
            begin
                sum_we    = 1'b1;
                sum_waddr = clr_reg;
            end
            S_LOAD:
            begin
                pos_we = 1'b1;
                sum_we = 1'b1;
            end
            S_ACC:
            begin
                // Read on the first phase, saturating write-back on the second.
                sum_we    = ph_reg;
                sum_waddr = acc_addr;
                sum_wdata = {sat_add(sz, norm_res.nz), sat_add(sy, norm_res.ny),
                             sat_add(sx, norm_res.nx)};
            end
            default:
            begin
            end
        endcase
    end

    assign norm_start = (state_reg == S_NSTART);
    assign nvx = (kind_reg == KIND_READ) ? CW'(sx) : c_reg[0];
    assign nvy = (kind_reg == KIND_READ) ? CW'(sy) : c_reg[1];
    assign nvz = (kind_reg == KIND_READ) ? CW'(sz) : c_reg[2];

    msvn_ram #(
        .WIDTH (3 * PW),
        .DEPTH (MAX_VERTS)
    ) u_pos_ram (
        .clk   (clk),
        .we    (pos_we),
        .waddr (vi),
        .wdata ({pz_reg, py_reg, px_reg}),
        .raddr (fetch_addr),
        .rdata (pos_rdata)
    );

    msvn_ram #(
        .WIDTH (3 * SUM_W),
        .DEPTH (MAX_VERTS)
    ) u_sum_ram (
        .clk   (clk),
        .we    (sum_we),
        .waddr (sum_waddr),
        .wdata (sum_wdata),
        .raddr (sum_raddr),
        .rdata (sum_rdata)
    );

    msvn_norm #(
        .VecWidth (CW)
    ) u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (norm_start),
        .vx    (nvx),
        .vy    (nvy),
        .vz    (nvz),
        .done  (norm_done),
        .res   (norm_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            ccount_reg    <= '0;
            face_cnt_reg  <= '0;
            step_reg      <= '0;
            acc_reg       <= '0;
            ph_reg        <= 1'b0;
            clr_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_EMIT && out_free)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result_valid && !result_stall)
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == LAST_V)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (item_accept && kind != KIND_UNUSED)
                    begin
                        state_reg <= S_RED;
                    end
                end
                S_RED:
                begin
                    if (!red_ge)
                    begin
                        case (kind_reg)
                            KIND_LOAD:   state_reg <= S_LOAD;
                            KIND_CORNER: state_reg <= S_CORNER;
                            default:     state_reg <= S_SREAD;
                        endcase
                    end
                end
                S_LOAD:
                begin
                    state_reg <= S_IDLE;
                end
                S_CORNER:
                begin
                    step_reg <= '0;
                    if (last_reg)
                    begin
                        ccount_reg   <= '0;
                        face_cnt_reg <= face_cnt_reg + 16'd1;
                        state_reg    <= (cnt_new >= CCW'(3)) ? S_FETCH : S_IDLE;
                    end
                    else
                    begin
                        ccount_reg <= cnt_new;
                        state_reg  <= S_IDLE;
                    end
                end
                S_FETCH:
                begin
                    if (step_reg == 3'd3)
                    begin
                        step_reg  <= '0;
                        state_reg <= S_CROSS;
                    end
                    else
                    begin
                        step_reg <= step_reg + 3'd1;
                    end
                end
                S_CROSS:
                begin
                    step_reg <= step_reg + 3'd1;
                    if (step_reg == 3'd6)
                    begin
                        state_reg <= S_NSTART;
                    end
                end
                S_SREAD:
                begin
                    state_reg <= S_NSTART;
                end
                S_NSTART:
                begin
                    state_reg <= S_NORM;
                end
                S_NORM:
                begin
                    acc_reg <= '0;
                    ph_reg  <= 1'b0;
                    if (norm_done)
                    begin
                        state_reg <= (kind_reg == KIND_READ) ? S_EMIT : S_ACC;
                    end
                end
                S_ACC:
                begin
                    ph_reg <= !ph_reg;
                    if (ph_reg)
                    begin
                        acc_reg <= acc_reg + CCW'(1);
                        if (acc_reg + CCW'(1) == nc_reg)
                        begin
                            state_reg <= S_EMIT;
                        end
                    end
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            kind_reg <= kind;
            red_reg  <= RW'(vertex_index);
            px_reg   <= px_in;
            py_reg   <= py_in;
            pz_reg   <= pz_in;
            last_reg <= last_corner;
        end
        if (state_reg == S_RED && red_ge)
        begin
            red_reg <= RW'(red_ext - VERTS_W);
        end
        if (state_reg == S_CORNER)
        begin
            if (has_room)
            begin
                corner_reg[ccount_reg[CBW-1:0]] <= vi;
            end
            if (last_reg)
            begin
                face_num_reg <= face_cnt_reg;
                nc_reg       <= cnt_new;
            end
        end
        if (state_reg == S_FETCH && step_reg != 3'd0)
        begin
            p_reg[step_reg[1:0] - 2'd1] <= pos_rdata;
        end
        if (state_reg == S_CROSS)
        begin
            if (step_reg <= 3'd5)
            begin
                prod_reg <= op1 * op2;
            end
            case (step_reg)
                3'd1:    c_reg[0] <= CW'(prod_reg);
                3'd2:    c_reg[0] <= c_reg[0] - CW'(prod_reg);
                3'd3:    c_reg[1] <= CW'(prod_reg);
                3'd4:    c_reg[1] <= c_reg[1] - CW'(prod_reg);
                3'd5:    c_reg[2] <= CW'(prod_reg);
                3'd6:    c_reg[2] <= c_reg[2] - CW'(prod_reg);
                default: c_reg[0] <= c_reg[0];
            endcase
        end
        if (state_reg == S_EMIT && out_free)
        begin
            res_kind_reg  <= (kind_reg == KIND_READ) ? RES_VERTEX : RES_FACE;
            res_index_reg <= (kind_reg == KIND_READ) ? 16'(vi) : face_num_reg;
            res_reg       <= norm_res;
        end
    end

    assign result_valid = res_valid_reg;
    assign result_kind  = res_kind_reg;
    assign result_index = res_index_reg;
    assign normal_x     = res_reg.nx;
    assign normal_y     = res_reg.ny;
    assign normal_z     = res_reg.nz;
    assign zero_length  = res_reg.zero;

    `MSVN_ASSERT(a_ccount_max, ccount_reg <= CORN_W)
    `MSVN_ASSERT(a_fetch_face, (state_reg == S_FETCH) |-> (nc_reg >= CCW'(3)))
    `MSVN_ASSERT(a_done_in_norm, norm_done |-> (state_reg == S_NORM))
    `MSVN_ASSERT_NEXT(a_emit_idle, (state_reg == S_EMIT) && !result_stall,
                      (state_reg == S_IDLE) && result_valid)

endmodule

`default_nettype wire

[verif/mesh_smooth_vertex_normals_tb.sv]
`timescale 1ns / 1ps

module mesh_smooth_vertex_normals_tb;
    import msvn_pkg::*;

    localparam int NVERT = 1024;
    localparam int NCORN = 8;
    localparam int IDLE_LIMIT = 20000;
    localparam int SUM_HI = 8388607;
    localparam int SUM_LO = -8388608;

    typedef struct {
        logic [1:0]         kind;
        logic [9:0]         vi;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [15:0] pz;
        logic               lc;
        bit                 drain;
    } request_t;

    typedef struct {
        logic      rkind;
        logic [15:0] idx;
        norm_res_t n;
    } normal_rec_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_stall;
    logic [1:0] kind = KIND_UNUSED;
    logic [9:0] vertex_index = '0;
    logic signed [15:0] pos_x = '0;
    logic signed [15:0] pos_y = '0;
    logic signed [15:0] pos_z = '0;
    logic last_corner = 1'b0;
    logic result_valid;
    logic result_stall = 1'b0;
    logic result_kind;
    logic [15:0] result_index;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic zero_length;

    mesh_smooth_vertex_normals dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .kind(kind),
        .vertex_index(vertex_index),
        .pos_x(pos_x),
        .pos_y(pos_y),
        .pos_z(pos_z),
        .last_corner(last_corner),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result_kind(result_kind),
        .result_index(result_index),
        .normal_x(normal_x),
        .normal_y(normal_y),
        .normal_z(normal_z),
        .zero_length(zero_length)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Predictor state.
    longint pos_tab [NVERT][3];
    int sum_x_tab [NVERT];
    int sum_y_tab [NVERT];
    int sum_z_tab [NVERT];
    int corner_buf [NCORN];
    int corner_cnt = 0;
    logic [15:0] face_ctr = '0;

    request_t pending_reqs[$];
    normal_rec_t expected_normals[$];
    int errors = 0;
    int faces_seen = 0;
    int reads_seen = 0;
    int zeros_seen = 0;
    int idle_cycles = 0;

    function automatic longint unsigned root64(input longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x = x - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic norm_res_t unit_normal(input longint cx, input longint cy,
                                              input longint cz);
        longint unsigned m0, m1, m2, mx, ss, len;
        longint q0, q1, q2;
        norm_res_t r;
        m0 = (cx < 0) ? -cx : cx;
        m1 = (cy < 0) ? -cy : cy;
        m2 = (cz < 0) ? -cz : cz;
        mx = m0;
        if (m1 > mx) mx = m1;
        if (m2 > mx) mx = m2;
        r = '0;
        if (mx == 0)
        begin
            r.zero = 1'b1;
            return r;
        end
        while (mx >= (64'd1 << 30))
        begin
            mx = mx >> 1; m0 = m0 >> 1; m1 = m1 >> 1; m2 = m2 >> 1;
        end
        while (mx < (64'd1 << 29))
        begin
            mx = mx << 1; m0 = m0 << 1; m1 = m1 << 1; m2 = m2 << 1;
        end
        ss = m0 * m0 + m1 * m1 + m2 * m2;
        len = root64(ss);
        q0 = (m0 * 16384 + len / 2) / len;
        q1 = (m1 * 16384 + len / 2) / len;
        q2 = (m2 * 16384 + len / 2) / len;
        r.nx = 16'((cx < 0) ? -q0 : q0);
        r.ny = 16'((cy < 0) ? -q1 : q1);
        r.nz = 16'((cz < 0) ? -q2 : q2);
        return r;
    endfunction

    function automatic int sat_sum(input int a, input int b);
        longint s;
        s = longint'(a) + longint'(b);
        if (s > SUM_HI) return SUM_HI;
        if (s < SUM_LO) return SUM_LO;
        return int'(s);
    endfunction

    // Updates the predictor with one accepted request and queues its result, if it has one.
    task automatic apply_request(input request_t r);
        int v, cnt, i, j;
        longint a [3];
        longint b [3];
        longint cx, cy, cz;
        normal_rec_t e;
        v = r.vi;
        if (r.kind == KIND_LOAD)
        begin
            pos_tab[v][0] = r.px;
            pos_tab[v][1] = r.py;
            pos_tab[v][2] = r.pz;
            sum_x_tab[v] = 0;
            sum_y_tab[v] = 0;
            sum_z_tab[v] = 0;
        end
        else if (r.kind == KIND_READ)
        begin
            e.rkind = RES_VERTEX;
            e.idx = 16'(v);
            e.n = unit_normal(sum_x_tab[v], sum_y_tab[v], sum_z_tab[v]);
            expected_normals.insert(expected_normals.size(), e);
        end
        else if (r.kind == KIND_CORNER)
        begin
            if (corner_cnt < NCORN)
            begin
                corner_buf[corner_cnt] = v;
                corner_cnt++;
            end
            if (r.lc)
            begin
                cnt = corner_cnt;
                e.idx = face_ctr;
                face_ctr = face_ctr + 16'd1;
                corner_cnt = 0;
                if (cnt >= 3)
                begin
                    for (j = 0; j < 3; j++)
                    begin
                        a[j] = pos_tab[corner_buf[0]][j] - pos_tab[corner_buf[1]][j];
                        b[j] = pos_tab[corner_buf[1]][j] - pos_tab[corner_buf[2]][j];
                    end
                    cx = a[1] * b[2] - a[2] * b[1];
                    cy = a[2] * b[0] - a[0] * b[2];
                    cz = a[0] * b[1] - a[1] * b[0];
                    e.rkind = RES_FACE;
                    e.n = unit_normal(cx, cy, cz);
                    for (i = 0; i < cnt; i++)
                    begin
                        sum_x_tab[corner_buf[i]] = sat_sum(sum_x_tab[corner_buf[i]],
                                                           int'(e.n.nx));
                        sum_y_tab[corner_buf[i]] = sat_sum(sum_y_tab[corner_buf[i]],
                                                           int'(e.n.ny));
                        sum_z_tab[corner_buf[i]] = sat_sum(sum_z_tab[corner_buf[i]],
                                                           int'(e.n.nz));
                    end
                    expected_normals.insert(expected_normals.size(), e);
                end
            end
        end
    endtask

    // Sender: bursts of requests separated by random gaps.
    request_t cur_req;
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            kind <= KIND_UNUSED;
            vertex_index <= '0;
            pos_x <= '0;
            pos_y <= '0;
            pos_z <= '0;
            last_corner <= 1'b0;
        end
        else if (!(item_valid && item_stall))
        begin
            if (item_valid)
                apply_request(cur_req);
            if (gap_left > 0)
            begin
                gap_left--;
                item_valid <= 1'b0;
            end
            else if (pending_reqs.size() > 0 &&
                     !(pending_reqs[0].drain && expected_normals.size() != 0))
            begin
                cur_req = pending_reqs.pop_front();
                item_valid <= 1'b1;
                kind <= cur_req.kind;
                vertex_index <= cur_req.vi;
                pos_x <= cur_req.px;
                pos_y <= cur_req.py;
                pos_z <= cur_req.pz;
                last_corner <= cur_req.lc;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
                else
                    burst_left--;
            end
            else
                item_valid <= 1'b0;
        end
    end

    // Receiver: the stall pattern moves in turn through no stall, random stall, mostly stalled and a toggling stall.
    int stall_cyc = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            stall_cyc++;
            case ((stall_cyc >> 7) % 4)
                0: result_stall <= 1'b0;
                1: result_stall <= $urandom_range(0, 1);
                2: result_stall <= ($urandom_range(0, 7) != 0);
                default: result_stall <= stall_cyc[3];
            endcase
        end
    end

    always @(posedge clk)
    begin
        normal_rec_t e;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_normals.size() == 0)
            begin
                $display("%0t: unexpected result kind %0d index %0d", $time,
                         result_kind, result_index);
                errors++;
            end
            else
            begin
                e = expected_normals.pop_front();
                if (result_kind == RES_FACE) faces_seen++;
                else reads_seen++;
                if (zero_length) zeros_seen++;
                if (result_kind !== e.rkind)
                begin
                    $display("%0t: result_kind expected %0d actual %0d", $time,
                             e.rkind, result_kind);
                    errors++;
                end
                if (result_index !== e.idx)
                begin
                    $display("%0t: result_index expected %0d actual %0d", $time,
                             e.idx, result_index);
                    errors++;
                end
                if (normal_x !== e.n.nx)
                begin
                    $display("%0t: normal_x expected %0d actual %0d", $time,
                             e.n.nx, normal_x);
                    errors++;
                end
                if (normal_y !== e.n.ny)
                begin
                    $display("%0t: normal_y expected %0d actual %0d", $time,
                             e.n.ny, normal_y);
                    errors++;
                end
                if (normal_z !== e.n.nz)
                begin
                    $display("%0t: normal_z expected %0d actual %0d", $time,
                             e.n.nz, normal_z);
                    errors++;
                end
                if (zero_length !== e.n.zero)
                begin
                    $display("%0t: zero_length expected %0d actual %0d", $time,
                             e.n.zero, zero_length);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a request or result.
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall) || !rst_n)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
            $display("mesh_smooth_vertex_normals_tb: FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Stimulus generation. Only loaded vertices are used as the first three
    // corners of a face, since their positions are read.
    int loaded_list[$];
    bit is_loaded [NVERT];

    task automatic push_req(input logic [1:0] k, input int vi, input int px, input int py,
                            input int pz, input bit lc, input bit drain);
        request_t r;
        r.kind = k;
        r.vi = 10'(vi);
        r.px = 16'(px);
        r.py = 16'(py);
        r.pz = 16'(pz);
        r.lc = lc;
        r.drain = drain;
        pending_reqs.insert(pending_reqs.size(), r);
        if (k == KIND_LOAD && !is_loaded[vi])
        begin
            is_loaded[vi] = 1'b1;
            loaded_list.insert(loaded_list.size(), vi);
        end
    endtask

    task automatic push_tri(input int v0, input int v1, input int v2);
        push_req(KIND_CORNER, v0, 0, 0, 0, 0, 0);
        push_req(KIND_CORNER, v1, 0, 0, 0, 0, 0);
        push_req(KIND_CORNER, v2, 0, 0, 0, 1, 0);
    endtask

    function automatic int rand_coord();
        if ($urandom_range(0, 2) == 0)
            return $signed(16'($urandom()));
        return $urandom_range(0, 4000) - 2000;
    endfunction

    function automatic int pick_loaded();
        return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
    endfunction

    initial
    begin
        int i, j, n, sel;
        // Directed part.
        push_req(KIND_LOAD, 0, 0, 0, 0, 0, 0);
        push_req(KIND_LOAD, 1, 256, 0, 0, 0, 0);
        push_req(KIND_LOAD, 2, 0, 256, 0, 0, 0);
        push_req(KIND_LOAD, 1023, -32768, 32767, -32768, 0, 0);
        push_req(KIND_LOAD, 512, 32767, -32768, 32767, 0, 0);
        push_tri(0, 1, 2);
        push_tri(1023, 512, 0);
        // Collinear corners give a zero vector.
        push_tri(0, 0, 1);
        // Short face: two corners only.
        push_req(KIND_CORNER, 1, 0, 0, 0, 0, 0);
        push_req(KIND_CORNER, 2, 0, 0, 0, 1, 0);
        // Corner overflow: ten corners, the last two are dropped.
        for (i = 0; i < 10; i++)
            push_req(KIND_CORNER, (i < 3) ? i : 300 + i, 0, 0, 0, i == 9, 0);
        push_req(KIND_UNUSED, 7, 1, 2, 3, 1, 0);
        push_req(KIND_READ, 0, 0, 0, 0, 0, 0);
        push_req(KIND_READ, 700, 0, 0, 0, 0, 0);
        push_req(KIND_READ, 1023, 0, 0, 0, 0, 1);
        push_req(KIND_LOAD, 0, 0, 0, 0, 0, 0);
        push_req(KIND_READ, 0, 0, 0, 0, 0, 0);

        // Faces that name one vertex several times, with sums of both signs;
        // vertex 1 takes six adds in each face of the first kind, vertex 3 in each of the second.
        push_req(KIND_LOAD, 3, 0, 0, 0, 0, 0);
        push_req(KIND_LOAD, 4, 0, 0, 256, 0, 0);
        push_req(KIND_LOAD, 5, 0, 256, 0, 0, 0);
        for (i = 0; i < 10; i++)
        begin
            for (j = 0; j < 8; j++)
                push_req(KIND_CORNER, (j == 0) ? 1 : (j == 1) ? 4 : (j == 2) ? 5 : 1,
                         0, 0, 0, j == 7, 0);
            for (j = 0; j < 8; j++)
                push_req(KIND_CORNER, (j == 0) ? 3 : (j == 1) ? 5 : (j == 2) ? 4 : 3,
                         0, 0, 0, j == 7, 0);
        end
        push_req(KIND_READ, 1, 0, 0, 0, 0, 0);
        push_req(KIND_READ, 3, 0, 0, 0, 0, 0);

        // Random part: loads, reads, unused requests and mostly well formed faces over loaded vertices.
        i = 0;
        while (i < 200)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 25)
            begin
                push_req(KIND_LOAD, $urandom_range(0, NVERT - 1), rand_coord(),
                         rand_coord(), rand_coord(), $urandom_range(0, 1), 0);
                i++;
            end
            else if (sel < 75)
            begin
                n = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 12) : 3;
                for (j = 0; j < n; j++)
                    push_req(KIND_CORNER,
                             (j < 3 && n >= 3) ? pick_loaded() : $urandom_range(0, NVERT - 1),
                             rand_coord(), rand_coord(), rand_coord(), j == n - 1, 0);
                i += n;
            end
            else if (sel < 95)
            begin
                push_req(KIND_READ, ($urandom_range(0, 3) == 0) ? $urandom_range(0, NVERT - 1)
                         : pick_loaded(), 0, 0, 0, $urandom_range(0, 1),
                         $urandom_range(0, 19) == 0);
                i++;
            end
            else
                push_req(KIND_UNUSED, $urandom_range(0, NVERT - 1), rand_coord(),
                         rand_coord(), rand_coord(), $urandom_range(0, 1), 0);
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || item_valid || expected_normals.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);

        $display("Checked %0d face normals and %0d vertex normal reads (%0d zero length),",
                 faces_seen, reads_seen, zeros_seen);
        $display("including corner overflow, short faces and repeated corners.");
        if (errors == 0 && expected_normals.size() == 0)
            $display("mesh_smooth_vertex_normals_tb: PASS");
        else
            $display("mesh_smooth_vertex_normals_tb: FAIL");
        $finish;
    end

endmodule

[mesh_smooth_vertex_normals.f]
+incdir+design
design/msvn_pkg.sv
design/msvn_ram.sv
design/msvn_norm.sv
design/mesh_smooth_vertex_normals.sv
verif/mesh_smooth_vertex_normals_tb.sv
